### hdl/smba_pkg.sv
`default_nettype none
package smba_pkg;

	localparam int FFT_SIZE = 1024;
	localparam int MAX_AVG  = 32;
	localparam int SPEC_LEN = FFT_SIZE / 2 + 1;
	localparam int ADDR_W   = $clog2(SPEC_LEN);
	localparam int IDX_W    = ADDR_W + 1;
	localparam int CNT_W    = $clog2(MAX_AVG + 1);
	localparam int ACC_W    = 16 + ADDR_W;
	localparam int DIVD_W   = 38;
	localparam int DIVS_W   = 27;
	localparam int F8_W     = 25;

	localparam logic [1:0] MODE_LIN = 2'd1;
	localparam logic [1:0] MODE_LOG = 2'd2;

	localparam logic [2:0] REG_AVG_MODE  = 3'd0;
	localparam logic [2:0] REG_LIN_GROUP = 3'd1;
	localparam logic [2:0] REG_SAMPLE_HZ = 3'd2;
	localparam logic [2:0] REG_MIN_BAND  = 3'd3;
	localparam logic [2:0] REG_BANDS_OCT = 3'd4;

	typedef struct packed {
		logic signed [15:0] re_part;
		logic signed [15:0] im_part;
		logic               last_bin;
	} smba_in_t;

	typedef struct packed {
		logic        kind;
		logic [9:0]  slot;
		logic [15:0] level;
		logic        end_of_run;
	} smba_out_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SQ_RE,
		ST_SQ_IM,
		ST_ROOT,
		ST_MAG,
		ST_LIN_W,
		ST_LIN_GOT,
		ST_OCT,
		ST_OCT_BEGIN,
		ST_STEP_GOT,
		ST_EDGE,
		ST_EDGE_GOT,
		ST_BAND,
		ST_SUM_INIT,
		ST_SUM,
		ST_SUM_DIV,
		ST_DIV_WAIT,
		ST_EMIT
	} smba_state_t;

endpackage
`default_nettype wire

### hdl/smba_div.sv
`default_nettype none
module smba_div import smba_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIVD_W-1:0] dividend,
	input  wire logic [DIVS_W-1:0] divisor,
	output logic                   busy,
	output logic [DIVD_W-1:0]      quot
);

	localparam int CW = $clog2(DIVD_W);

	logic              busy_q;
	logic [CW-1:0]     cnt_q;
	logic [DIVD_W-1:0] q_q;
	logic [DIVS_W:0]   r_q;
	logic [DIVS_W-1:0] d_q;
	logic [DIVS_W:0]   r_sh;
	logic              take;

	// one quotient bit per cycle, restoring
	assign r_sh = {r_q[DIVS_W-1:0], q_q[DIVD_W-1]};
	assign take = r_sh >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(DIVD_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0)
				busy_q <= 1'b0;
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			r_q <= take ? (r_sh - {1'b0, d_q}) : r_sh;
			q_q <= {q_q[DIVD_W-2:0], take};
		end
	end

	assign busy = busy_q;
	assign quot = q_q;

endmodule
`default_nettype wire

### hdl/spectrum_magnitude_band_averager_core.sv
`default_nettype none
// Flow: after start is taken, a bin passes through two squaring states, sixteen
// root steps, then one state that writes the store and loads the output register;
// res_valid is registered. The block takes a new bin only once it is idle again.
// On a last bin in linear or log mode the averages follow, each one computed
// with the shared serial divider.
// Reset (arst_n low, asynchronous) clears the state and control registers;
// the datapath registers and the store are not reset.
module spectrum_magnitude_band_averager_core import smba_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	output logic           busy,
	input  wire smba_in_t  item,
	output logic           res_valid,
	output smba_out_t      res,
	input  wire logic      cfg_valid,
	output logic           cfg_ready,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [17:0] cfg_data
);

	localparam logic [36:0] TWO_T = 37'(2 * FFT_SIZE);

	smba_state_t state_q, state_d, ret_q;

	// configuration registers
	logic [1:0]  mode_q;
	logic [5:0]  grp_q;
	logic [17:0] sr_q;
	logic [16:0] minb_q;
	logic [5:0]  bpo_q;

	smba_in_t        in_q;
	logic [ADDR_W-1:0] bin_idx_q;
	logic [31:0]     sq_q, v_q, root_q;
	logic [3:0]      it_q;
	logic [4:0]      oct_q, i_q;
	logic [19:0]     msh_q;
	logic [5:0]      j_q;
	logic [CNT_W-1:0] cnt_q;
	logic [F8_W-1:0] f8_q, step8_q;
	logic [IDX_W-1:0] w_q, lo_q, hi_q, addr_q;
	logic [IDX_W:0]  divisor_q;
	logic [ACC_W-1:0] acc_q;
	logic [15:0]     rd_s1;
	logic            rvld_s1;
	logic            sel_q;
	logic            res_valid_q;
	smba_out_t       res_q;

	logic [15:0] mem [SPEC_LEN];

	// shared divider
	logic              div_start, div_busy;
	logic [DIVD_W-1:0] div_a, div_quot;
	logic [DIVS_W-1:0] div_b;

	smba_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.busy     (div_busy),
		.quot     (div_quot)
	);

	// effective values: raised to the legal minimum, group capped at MAX_AVG
	logic [5:0]  g_eff, b_eff;
	logic [16:0] m_eff, h;
	logic [17:0] sr_eff;
	logic [F8_W-1:0] hsh, low8, high8, fe;
	logic [4:0]  sh;
	logic [36:0] ea, lo_lim, hi_lim;
	logic        edge_div;
	logic signed [15:0] mul_in;
	logic signed [31:0] prod;
	logic [31:0] root_bit, root_try;
	logic        issue;
	logic [CNT_W-1:0] cnt_n;
	logic        lin_more, j_more, i_more, log_more, more;
	logic [IDX_W-1:0] edge_val;
	logic        is_lin;

	always_comb begin
		g_eff = (grp_q == '0) ? 6'd1 : ((grp_q > 6'(MAX_AVG)) ? 6'(MAX_AVG) : grp_q);
		b_eff = (bpo_q == '0) ? 6'd1 : bpo_q;
		m_eff = (minb_q == '0) ? 17'd1 : minb_q;
		sr_eff = (sr_q < 18'd2) ? 18'd2 : sr_q;
		h = sr_eff[17:1];
		hsh = {h, 8'b0};
		sh = oct_q - i_q;
		low8 = (i_q == '0) ? '0 : (hsh >> sh);
		high8 = hsh >> (sh - 5'd1);
		fe = sel_q ? (f8_q + step8_q) : f8_q;
		ea = 37'(fe) * TWO_T;
		lo_lim = 37'({sr_eff, 8'b0});
		hi_lim = (37'(h) * TWO_T - 37'(sr_eff)) << 8;
		edge_div = !(ea < lo_lim || ea > hi_lim);
		mul_in = (state_q == ST_SQ_RE) ? in_q.re_part : in_q.im_part;
		prod = mul_in * mul_in;
		root_bit = 32'd1 << (5'd30 - {it_q, 1'b0});
		root_try = root_q + root_bit;
		issue = (state_q == ST_SUM) && (addr_q <= hi_q);
		is_lin = (mode_q == MODE_LIN);
		cnt_n = cnt_q + 1'b1;
		lin_more = 6'(cnt_n) < g_eff;
		j_more = (7'(j_q) + 7'd1) < 7'(b_eff);
		i_more = (i_q + 5'd1) < oct_q;
		log_more = (cnt_n != CNT_W'(MAX_AVG)) && (j_more || i_more);
		more = is_lin ? lin_more : log_more;
		if (ea < lo_lim)
			edge_val = '0;
		else
			edge_val = IDX_W'(SPEC_LEN - 1);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_a     = '0;
		div_b     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start)
					state_d = ST_SQ_RE;
			end
			ST_SQ_RE: state_d = ST_SQ_IM;
			ST_SQ_IM: state_d = ST_ROOT;
			ST_ROOT: begin
				if (it_q == 4'd15)
					state_d = ST_MAG;
			end
			ST_MAG: begin
				if (in_q.last_bin && mode_q == MODE_LIN)
					state_d = ST_LIN_W;
				else if (in_q.last_bin && mode_q == MODE_LOG)
					state_d = ST_OCT;
				else
					state_d = ST_IDLE;
			end
			ST_LIN_W: begin
				div_start = 1'b1;
				div_a     = DIVD_W'(SPEC_LEN);
				div_b     = DIVS_W'(g_eff);
				state_d   = ST_DIV_WAIT;
			end
			ST_LIN_GOT: state_d = ST_SUM_INIT;
			ST_OCT: begin
				if (!(msh_q < 20'(sr_eff)))
					state_d = ST_OCT_BEGIN;
			end
			ST_OCT_BEGIN: begin
				div_start = 1'b1;
				div_a     = DIVD_W'(high8 - low8);
				div_b     = DIVS_W'(b_eff);
				state_d   = ST_DIV_WAIT;
			end
			ST_STEP_GOT: state_d = ST_EDGE;
			ST_EDGE: begin
				if (edge_div) begin
					div_start = 1'b1;
					div_a     = DIVD_W'(ea + (37'(sr_eff) << 8));
					div_b     = DIVS_W'({sr_eff, 9'b0});
					state_d   = ST_DIV_WAIT;
				end else if (sel_q) begin
					state_d = ST_BAND;
				end
			end
			ST_EDGE_GOT: state_d = sel_q ? ST_BAND : ST_EDGE;
			ST_BAND: state_d = ST_SUM_INIT;
			ST_SUM_INIT: state_d = ST_SUM;
			ST_SUM: begin
				if (!issue && !rvld_s1)
					state_d = ST_SUM_DIV;
			end
			ST_SUM_DIV: begin
				div_start = 1'b1;
				div_a     = DIVD_W'(acc_q);
				div_b     = DIVS_W'(divisor_q);
				state_d   = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (!div_busy)
					state_d = ret_q;
			end
			ST_EMIT: begin
				if (!more)
					state_d = ST_IDLE;
				else if (is_lin)
					state_d = ST_SUM_INIT;
				else if (j_more)
					state_d = ST_EDGE;
				else
					state_d = ST_OCT_BEGIN;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers: configuration, bin counter, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 2'd0;
			grp_q       <= 6'd1;
			sr_q        <= 18'd48000;
			minb_q      <= 17'd22;
			bpo_q       <= 6'd1;
			bin_idx_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_addr)
					REG_AVG_MODE:  mode_q <= cfg_data[1:0];
					REG_LIN_GROUP: grp_q  <= cfg_data[5:0];
					REG_SAMPLE_HZ: sr_q   <= cfg_data;
					REG_MIN_BAND:  minb_q <= cfg_data[16:0];
					REG_BANDS_OCT: bpo_q  <= cfg_data[5:0];
					default: ;
				endcase
			end
			res_valid_q <= (state_q == ST_MAG) || (state_q == ST_EMIT);
			if (state_q == ST_MAG) begin
				// wrap at the end of a frame, restart on the last bin
				if (in_q.last_bin || bin_idx_q == ADDR_W'(SPEC_LEN - 1))
					bin_idx_q <= '0;
				else
					bin_idx_q <= bin_idx_q + 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: in_q <= item;
			ST_SQ_RE: sq_q <= 32'(prod);
			ST_SQ_IM: begin
				v_q    <= sq_q + 32'(prod);
				root_q <= '0;
				it_q   <= '0;
			end
			ST_ROOT: begin
				// one result bit per cycle
				if (v_q >= root_try) begin
					v_q    <= v_q - root_try;
					root_q <= (root_q >> 1) + root_bit;
				end else begin
					root_q <= root_q >> 1;
				end
				it_q <= it_q + 1'b1;
			end
			ST_MAG: begin
				res_q.kind       <= 1'b0;
				res_q.slot       <= 10'(bin_idx_q);
				res_q.level      <= root_q[15:0];
				res_q.end_of_run <= !(in_q.last_bin &&
					(mode_q == MODE_LIN || mode_q == MODE_LOG));
				oct_q <= 5'd1;
				msh_q <= 20'(m_eff) << 2;
				cnt_q <= '0;
				i_q   <= '0;
			end
			ST_LIN_W: ret_q <= ST_LIN_GOT;
			ST_LIN_GOT: begin
				w_q       <= div_quot[IDX_W-1:0];
				lo_q      <= '0;
				hi_q      <= div_quot[IDX_W-1:0] - 1'b1;
				divisor_q <= {1'b0, div_quot[IDX_W-1:0]} + 1'b1;
			end
			ST_OCT: begin
				// count octaves while the widened minimum band stays below the rate
				if (msh_q < 20'(sr_eff)) begin
					oct_q <= oct_q + 1'b1;
					msh_q <= msh_q << 1;
				end
			end
			ST_OCT_BEGIN: begin
				f8_q  <= low8;
				j_q   <= '0;
				ret_q <= ST_STEP_GOT;
			end
			ST_STEP_GOT: begin
				step8_q <= div_quot[F8_W-1:0];
				sel_q   <= 1'b0;
			end
			ST_EDGE: begin
				if (edge_div) begin
					ret_q <= ST_EDGE_GOT;
				end else begin
					if (sel_q)
						hi_q <= edge_val;
					else
						lo_q <= edge_val;
					sel_q <= 1'b1;
				end
			end
			ST_EDGE_GOT: begin
				if (sel_q)
					hi_q <= (div_quot > DIVD_W'(SPEC_LEN - 1)) ?
						IDX_W'(SPEC_LEN - 1) : div_quot[IDX_W-1:0];
				else
					lo_q <= (div_quot > DIVD_W'(SPEC_LEN - 1)) ?
						IDX_W'(SPEC_LEN - 1) : div_quot[IDX_W-1:0];
				sel_q <= 1'b1;
			end
			ST_BAND: begin
				divisor_q <= (hi_q < lo_q) ? (IDX_W + 1)'(1) :
					({1'b0, hi_q} - {1'b0, lo_q} + 1'b1);
			end
			ST_SUM_INIT: begin
				addr_q  <= lo_q;
				acc_q   <= '0;
				rvld_s1 <= 1'b0;
			end
			ST_SUM: begin
				if (issue)
					addr_q <= addr_q + 1'b1;
				rvld_s1 <= issue;
				if (rvld_s1)
					acc_q <= acc_q + ACC_W'(rd_s1);
			end
			ST_SUM_DIV: ret_q <= ST_EMIT;
			ST_EMIT: begin
				res_q.kind       <= 1'b1;
				res_q.slot       <= 10'(cnt_q);
				res_q.level      <= div_quot[15:0];
				res_q.end_of_run <= !more;
				cnt_q <= cnt_n;
				if (is_lin) begin
					lo_q <= lo_q + w_q;
					hi_q <= hi_q + w_q;
				end else if (j_more) begin
					f8_q  <= f8_q + step8_q;
					j_q   <= j_q + 1'b1;
					sel_q <= 1'b0;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// magnitude store: written once per bin, read while walking a band
	always_ff @(posedge clk) begin
		if (state_q == ST_MAG)
			mem[bin_idx_q] <= root_q[15:0];
		if (issue)
			rd_s1 <= mem[addr_q[ADDR_W-1:0]];
	end

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
`default_nettype wire

### hdl/smba_chk.sv
`default_nettype none
module smba_chk import smba_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      start,
	input wire logic      busy,
	input wire logic      res_valid,
	input wire smba_out_t res
);

	// a result only follows a cycle of work
	a_res_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $past(busy)) else $error("result without work");

	// an accepted transaction holds the block busy
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("start not taken");

	// no result right after a new transaction is taken
	a_no_early_res: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !res_valid) else $error("early result");

	// the final result of a run is not followed at once by another
	a_end_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.end_of_run) |=> !res_valid) else $error("result after end");

	// more results are due after one without the end flag
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.end_of_run) |-> busy) else $error("run dropped");

endmodule

bind spectrum_magnitude_band_averager_core smba_chk u_smba_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.res_valid (res_valid),
	.res       (res)
);
`default_nettype wire
